### design/life_grid_generation_step_core_macros.svh
// Assertion macros for the checker file of the life grid core.
`ifndef LIFE_GRID_GENERATION_STEP_CORE_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_CORE_MACROS_SVH

// Check a property on every rising edge, muted while reset is held.
`define LGS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Check a property on every rising edge, reset included.
`define LGS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

### design/lgs_pkg.sv
// Package for the life grid core: kinds, controller states, command structs.
`default_nettype none

package lgs_pkg;

    localparam int SIDE_DEFAULT = 16;

    // B3/S23 neighbor counts
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic access;      // perform a write/read/no-op transaction now
        logic sweep_init;  // clear window, counter and flags
        logic sweep_step;  // advance the row sweep by one
    } t_cmd;

    typedef struct packed {
        logic last;        // sweep is on its final row
    } t_status;

endpackage

`default_nettype wire

### design/lgs_ctrl.sv
// Controller state machine for the life grid core.
`default_nettype none

module lgs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_kind,
    input  wire lgs_pkg::t_status i_status,
    output lgs_pkg::t_cmd         o_cmd,
    output logic                  busy
);

    lgs_pkg::t_state r_state;
    lgs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (start) begin
                    if (lgs_pkg::t_kind'(i_kind) == lgs_pkg::KIND_STEP) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = lgs_pkg::ST_SWEEP;
                    end else begin
                        o_cmd.access = 1'b1;
                    end
                end
            end
            lgs_pkg::ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.last) begin
                    n_state = lgs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state == lgs_pkg::ST_SWEEP);

endmodule

`default_nettype wire

### design/lgs_datapath.sv
// Datapath for the life grid core: grid stores, row window, rule and flags.
`default_nettype none

module lgs_datapath #(
    parameter int SIDE = lgs_pkg::SIDE_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lgs_pkg::t_cmd i_cmd,
    input  wire logic [1:0]    i_kind,
    input  wire logic [3:0]    i_row,
    input  wire logic [3:0]    i_col,
    input  wire logic          i_alive,
    output lgs_pkg::t_status   o_status,
    output logic               o_strobe,
    output logic               o_cell_value,
    output logic               o_all_dead,
    output logic               o_unchanged,
    output logic               o_period_two
);

    localparam int AW = $clog2(SIDE);
    localparam int KW = $clog2(SIDE + 2);

    logic [SIDE-1:0] r_cur  [SIDE];
    logic [SIDE-1:0] r_prev [SIDE];
    logic [SIDE-1:0] r_two  [SIDE];

    logic [SIDE-1:0] r_win_a;
    logic [SIDE-1:0] r_win_m;
    logic [SIDE-1:0] r_win_b;
    logic [KW-1:0]   r_k;
    logic            r_empty;
    logic            r_same1;
    logic            r_same2;

    logic            r_strobe;
    logic            r_cell;
    logic            r_dead;
    logic            r_unch;
    logic            r_p2;

    logic            in_grid;
    logic [AW-1:0]   row_idx;
    logic [AW-1:0]   col_idx;
    logic [AW-1:0]   rd_addr;
    logic [SIDE-1:0] rd_row;
    logic [SIDE-1:0] load_row;
    logic            proc;
    logic            last;
    logic [AW-1:0]   pidx;
    logic [SIDE-1:0] fresh;
    logic [SIDE-1:0] prev_row;
    logic            row_empty;
    logic            row_same1;
    logic            row_same2;
    logic            do_write;

    assign in_grid = (int'(i_row) < SIDE) && (int'(i_col) < SIDE);
    assign row_idx = AW'(i_row);
    assign col_idx = AW'(i_col);

    // single read port on the current grid, shared by sweep and cell reads
    assign rd_addr  = i_cmd.sweep_step ? r_k[AW-1:0] : row_idx;
    assign rd_row   = r_cur[rd_addr];
    assign load_row = (r_k < KW'(SIDE)) ? rd_row : '0;

    assign last = (r_k == KW'(SIDE + 1));
    assign proc = i_cmd.sweep_step && (r_k >= KW'(2));
    assign pidx = AW'(r_k - KW'(2));

    assign o_status.last = last;

    // B3/S23 on the middle window row, zero padding at both edges
    always_comb begin
        logic [SIDE+1:0] a;
        logic [SIDE+1:0] m;
        logic [SIDE+1:0] b;
        logic [3:0]      n;
        a = {1'b0, r_win_a, 1'b0};
        m = {1'b0, r_win_m, 1'b0};
        b = {1'b0, r_win_b, 1'b0};
        fresh = '0;
        for (int c = 0; c < SIDE; c++) begin
            n = 4'(a[c]) + 4'(a[c+1]) + 4'(a[c+2]) + 4'(m[c]) + 4'(m[c+2])
              + 4'(b[c]) + 4'(b[c+1]) + 4'(b[c+2]);
            fresh[c] = (n == 4'(lgs_pkg::BIRTH_COUNT))
                    || ((n == 4'(lgs_pkg::SURVIVE_COUNT)) && m[c+1]);
        end
    end

    assign prev_row  = r_prev[pidx];
    assign row_empty = (fresh == '0);
    assign row_same1 = (fresh == r_win_m);
    assign row_same2 = (fresh == prev_row);

    assign do_write = i_cmd.access && in_grid
                   && (lgs_pkg::t_kind'(i_kind) == lgs_pkg::KIND_WRITE);

    // grid stores: cell write when idle, in-place row update during the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SIDE; r++) begin
                r_cur[r]  <= '0;
                r_prev[r] <= '0;
                r_two[r]  <= '0;
            end
        end else begin
            if (do_write) begin
                r_cur[row_idx][col_idx] <= i_alive;
            end
            if (proc) begin
                r_cur[pidx]  <= fresh;
                r_prev[pidx] <= r_win_m;
                r_two[pidx]  <= prev_row;
            end
        end
    end

    // row window, sweep counter and running flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.sweep_init) begin
            r_k <= '0;
        end else if (i_cmd.sweep_step) begin
            r_k <= r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_init) begin
            r_win_a <= '0;
            r_win_m <= '0;
            r_win_b <= '0;
            r_empty <= 1'b1;
            r_same1 <= 1'b1;
            r_same2 <= 1'b1;
        end else if (i_cmd.sweep_step) begin
            r_win_a <= r_win_m;
            r_win_m <= r_win_b;
            r_win_b <= load_row;
            if (proc) begin
                r_empty <= r_empty & row_empty;
                r_same1 <= r_same1 & row_same1;
                r_same2 <= r_same2 & row_same2;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.access || (i_cmd.sweep_step && last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.access) begin
            r_cell <= in_grid && rd_row[col_idx]
                   && (lgs_pkg::t_kind'(i_kind) == lgs_pkg::KIND_READ);
            r_dead <= 1'b0;
            r_unch <= 1'b0;
            r_p2   <= 1'b0;
        end else if (i_cmd.sweep_step && last) begin
            r_cell <= 1'b0;
            r_dead <= r_empty & row_empty;
            r_unch <= r_same1 & row_same1;
            r_p2   <= r_same2 & row_same2;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_cell_value = r_cell;
    assign o_all_dead   = r_dead;
    assign o_unchanged  = r_unch;
    assign o_period_two = r_p2;

endmodule

`default_nettype wire

### design/life_grid_generation_step_core.sv
// Top level of the life grid core: B3/S23 on a bounded SIDE x SIDE grid.
//
// Usage: drive i_kind, i_row, i_col and i_alive with start high; the
// transaction is taken at a rising edge where start is high and busy low.
// A write or read transaction keeps busy low and returns its result in the
// cycle after acceptance, so such transactions may follow every cycle.
// A generation step raises busy while the grid is swept one row per
// cycle through a three-row window, which fills ahead of the first row.
// The result appears in the same cycle as busy falls. The single read
// port on the current grid sets the pace of the sweep.
// Each result is shown for one cycle with o_strobe high; the receiver
// cannot stall it. Writes and reads return zero flags; a step returns
// o_cell_value zero. Reset is synchronous and clears all three grids.
`default_nettype none

module life_grid_generation_step_core #(
    parameter int SIDE = lgs_pkg::SIDE_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_kind,
    input  wire logic [3:0] i_row,
    input  wire logic [3:0] i_col,
    input  wire logic       i_alive,
    output logic            o_strobe,
    output logic            o_cell_value,
    output logic            o_all_dead,
    output logic            o_unchanged,
    output logic            o_period_two
);

    lgs_pkg::t_cmd    cmd;
    lgs_pkg::t_status status;

    lgs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    lgs_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_alive      (i_alive),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_cell_value (o_cell_value),
        .o_all_dead   (o_all_dead),
        .o_unchanged  (o_unchanged),
        .o_period_two (o_period_two)
    );

endmodule

`default_nettype wire

### design/lgs_checker.sv
// Port-level checker for the life grid core, bound to the top level.
`default_nettype none
`include "life_grid_generation_step_core_macros.svh"

module lgs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_kind,
    input wire logic       o_strobe,
    input wire logic       o_cell_value,
    input wire logic       o_all_dead,
    input wire logic       o_unchanged,
    input wire logic       o_period_two
);

    logic take_step;
    logic take_access;

    assign take_step   = start && !busy && (i_kind == lgs_pkg::KIND_STEP);
    assign take_access = start && !busy && (i_kind != lgs_pkg::KIND_STEP);

    `LGS_ASSERT(a_step_busy, i_clk, i_rst_n, take_step |=> busy && !o_strobe)
    `LGS_ASSERT(a_access_result, i_clk, i_rst_n, take_access |=> o_strobe && !busy)
    `LGS_ASSERT(a_step_result, i_clk, i_rst_n, $fell(busy) |-> o_strobe)
    `LGS_ASSERT(a_read_no_flags, i_clk, i_rst_n,
        o_strobe && o_cell_value |-> !o_all_dead && !o_unchanged && !o_period_two)
    `LGS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !busy && !o_strobe)

endmodule

bind life_grid_generation_step_core lgs_checker u_lgs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_kind       (i_kind),
    .o_strobe     (o_strobe),
    .o_cell_value (o_cell_value),
    .o_all_dead   (o_all_dead),
    .o_unchanged  (o_unchanged),
    .o_period_two (o_period_two)
);

`default_nettype wire
